[hw/rtl/hsfd_pkg.sv]
// Package for the humidity sensor frame decoder: constants, CRC and scaling helpers.
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef logic [2:0] pos_t;

    localparam pos_t POS_T_MSB = 3'd0;
    localparam pos_t POS_T_LSB = 3'd1;
    localparam pos_t POS_T_CRC = 3'd2;
    localparam pos_t POS_H_MSB = 3'd3;
    localparam pos_t POS_H_LSB = 3'd4;
    localparam pos_t POS_H_CRC = 3'd5;

    // Full-scale spans in hundredths
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] HUMID_SPAN  = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // Half of 65535, rounded down: the rounding term once the factor of two is cancelled
    localparam logic [30:0] ROUND_HALF  = 31'd32767;
    localparam logic [16:0] WORD_MAX    = 17'd65535;

    typedef logic [30:0] prod_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // floor(y / 65535) with y = p + 32767 < 2^31: y = a*65536 + b gives
    // y = a*65535 + (a + b), and a + b stays below twice 65535.
    function automatic logic [14:0] div_word_max(input prod_t p);
        prod_t       y;
        logic [16:0] sum;
        y   = p + ROUND_HALF;
        sum = {2'b00, y[30:16]} + {1'b0, y[15:0]};
        return y[30:16] + ((sum >= WORD_MAX) ? 15'd1 : 15'd0);
    endfunction

endpackage

[hw/rtl/humidity_sensor_frame_decoder_top.sv]
// Top level of the humidity sensor frame decoder: byte framing, CRC check and scaling.
//
//   channel | direction | handshake          | payload
//   in      | request   | in_valid/in_stall  | data_byte[7:0], frame_start
//   out     | result    | out_valid/out_stall| temperature_centi[14:0] signed,
//           |           |                    | humidity_centi[13:0], reading_valid
//
// One byte is taken per cycle while in_stall is low. The sixth byte of a frame gives
// one result through a constant multiply stage, then a divide-by-65535 correction
// into the output register. Asynchronous active-low reset clears the byte count and
// pipeline valids and sets the CRC to its initial value. in_stall rises only while
// both the product stage and the output register hold results and out_stall is high.
module humidity_sensor_frame_decoder_top
    import hsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               reading_valid
);

    pos_t        pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_temp_reg, raw_temp_next;
    logic [15:0] raw_humid_reg, raw_humid_next;
    logic        temp_ok_reg, temp_ok_next;

    logic        prod_valid_reg;
    prod_t       prod_temp_reg, prod_humid_reg;
    logic        prod_ok_reg;

    logic        out_valid_reg;
    logic [14:0] temp_out_reg;
    logic [13:0] humid_out_reg;
    logic        ok_out_reg;

    pos_t        pos_cur;
    logic [7:0]  crc_cur;
    logic [7:0]  crc_step;
    logic        accept;
    logic        frame_done;
    logic        frame_ok;
    logic        out_free;
    logic        prod_move;
    logic [14:0] temp_q;
    logic [14:0] humid_q;

    assign out_free  = !out_valid_reg || !out_stall;
    assign prod_move = prod_valid_reg && out_free;
    assign in_stall  = prod_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;

    // Start flag restarts the frame before this byte is taken
    always_comb
    begin
        if (frame_start)
            pos_cur = POS_T_MSB;
        else if (pos_reg > POS_H_CRC)
            pos_cur = POS_T_MSB;
        else
            pos_cur = pos_reg;
        crc_cur  = frame_start ? CRC_INIT : crc_reg;
        crc_step = crc8_byte(crc_cur, data_byte);
    end

    always_comb
    begin
        raw_temp_next  = raw_temp_reg;
        raw_humid_next = raw_humid_reg;
        temp_ok_next   = temp_ok_reg;
        crc_next       = crc_step;
        frame_done     = 1'b0;
        pos_next       = (pos_cur == POS_H_CRC) ? POS_T_MSB : pos_t'(pos_cur + 3'd1);
        unique case (pos_cur)
            POS_T_MSB: raw_temp_next  = {data_byte, raw_temp_reg[7:0]};
            POS_T_LSB: raw_temp_next  = {raw_temp_reg[15:8], data_byte};
            POS_T_CRC:
            begin
                temp_ok_next = (crc_cur == data_byte);
                crc_next     = CRC_INIT;
            end
            POS_H_MSB: raw_humid_next = {data_byte, raw_humid_reg[7:0]};
            POS_H_LSB: raw_humid_next = {raw_humid_reg[15:8], data_byte};
            default:
            begin
                frame_done = 1'b1;
                crc_next   = CRC_INIT;
            end
        endcase
    end

    assign frame_ok = temp_ok_reg && (crc_cur == data_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            raw_temp_reg  <= 16'd0;
            raw_humid_reg <= 16'd0;
            temp_ok_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            raw_temp_reg  <= raw_temp_next;
            raw_humid_reg <= raw_humid_next;
            temp_ok_reg   <= temp_ok_next;
        end
    end

    // Product stage: span * raw word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (accept && frame_done)
            prod_valid_reg <= 1'b1;
        else if (prod_move)
            prod_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && frame_done)
        begin
            prod_temp_reg  <= prod_t'(raw_temp_reg) * prod_t'(TEMP_SPAN);
            prod_humid_reg <= prod_t'(raw_humid_reg) * prod_t'(HUMID_SPAN);
            prod_ok_reg    <= frame_ok;
        end
    end

    assign temp_q  = div_word_max(prod_temp_reg);
    assign humid_q = div_word_max(prod_humid_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (prod_move)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (prod_move)
        begin
            temp_out_reg  <= prod_ok_reg ? (temp_q - TEMP_OFFSET) : 15'd0;
            humid_out_reg <= prod_ok_reg ? humid_q[13:0] : 14'd0;
            ok_out_reg    <= prod_ok_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = signed'(temp_out_reg);
    assign humidity_centi    = humid_out_reg;
    assign reading_valid     = ok_out_reg;

endmodule
